// ===== sv/hbd_pkg.sv =====
// Package for the hole border detector: payload structs, register indexes
// and fixed field widths shared by the top level and its ports.
// No dependencies.
package hbd_pkg;

    // Field and register widths
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int COUNT_W   = 21;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [CFG_W-1:0]   ROW_SAT   = {CFG_W{1'b1}};
    localparam logic [CFG_W-1:0]   SIZE_RESET = 11'd1024;

    // Steps of the bit-serial position divider
    localparam logic [4:0] DIV_STEPS = 5'(COUNT_W);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // Request command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] mask_value;
    } t_in_item;

    typedef struct packed {
        logic               is_border;
        logic               frame_last;
        logic [COUNT_W-1:0] border_count;
    } t_out_item;

endpackage

// ===== sv/hole_border_detect.sv =====
// Hole border detector: 8-connected inner boundary of a raster hole mask.
// Throughput: one request per cycle unless the divider runs, a cfg write
// is offered or the output stalls. A result moves from the window stage
// register to the output register. A write of image_width recomputes the
// output row/column in a bit-serial divider; no request is taken then.
// Reset (synchronous, active low): 1024x1024 size, empty frame; line store
// contents stay undefined.
module hole_border_detect
    import hbd_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Pixel request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    // Result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    // Configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // Configuration and effective sizes
    logic [CFG_W-1:0]   r_width, r_height;
    logic [CFG_W-1:0]   w_eff, h_eff;
    logic [COUNT_W-1:0] w21, h21;

    // Position counters
    logic [CFG_W-1:0]   r_in_row, r_in_col, n_in_row, n_in_col;
    logic [COUNT_W-1:0] r_out_pos, n_out_pos;
    logic [COUNT_W-1:0] r_out_row, n_out_row;
    logic [CFG_W-1:0]   r_out_col, n_out_col;
    logic [CFG_W-1:0]   col_inc;

    // Position divider
    logic [4:0]         r_div_cnt;
    logic [COUNT_W-1:0] r_div_q, n_div_q;
    logic [CFG_W-1:0]   r_div_rem, n_div_rem;
    logic [CFG_W:0]     div_trial;
    logic               div_busy;

    // Accept-side decode
    logic               in_accept, cfg_we;
    logic               hole0, emit0, last0;
    logic [2:0]         rowok0;
    logic [1:0]         colok0;
    logic [31:0]        col32;
    logic [AW-1:0]      rd_addr;

    // Window stage
    logic               r_a_valid, r_a_emit, r_a_hole, r_a_last;
    logic [2:0]         r_a_rowok;
    logic [1:0]         r_a_colok;
    logic [AW-1:0]      r_a_addr;
    logic               a_go;
    logic [1:0]         ram_rdata, line_rd, wr_data;
    logic               r_byp;
    logic [1:0]         r_byp_data;
    logic [8:0]         r_window, nw;
    logic               border;
    logic [COUNT_W-1:0] r_total, n_total;

    // Output register
    logic               r_o_valid;
    t_out_item          r_o_data;

    // Clamp the size registers
    always_comb begin
        if (r_width == '0) begin
            w_eff = 11'd1;
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_eff = CFG_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = 11'd1;
        end else if (32'(r_height) > MAX_HEIGHT) begin
            h_eff = CFG_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    assign w21 = COUNT_W'(w_eff);
    assign h21 = COUNT_W'(h_eff);

    // Handshakes
    assign div_busy    = (r_div_cnt != '0);
    assign a_go        = r_a_valid && (!r_o_valid || i_out_ready);
    assign o_in_ready  = !div_busy && !i_cfg_valid && (!r_a_valid || a_go);
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Decode the request against the current positions
    always_comb begin
        hole0 = (i_in_data.cmd == CMD_PIXEL) && (r_in_row < h_eff)
                && (i_in_data.mask_value != 8'd0);
        col32 = (32'(r_in_col) >= MAX_WIDTH) ? 32'(MAX_WIDTH - 1) : 32'(r_in_col);
        rd_addr = col32[AW-1:0];

        emit0 = !(((r_in_row == '0) && (r_in_col <= w_eff))
                  || ((r_in_row == 11'd1) && (r_in_col == '0)));

        rowok0[0] = (r_out_row != '0) && (r_out_row <= h21);
        rowok0[1] = (r_out_row < h21);
        rowok0[2] = (r_out_row < (h21 - 21'd1));
        colok0[0] = (r_out_col != '0);
        colok0[1] = (({1'b0, r_out_col} + 12'd1) < {1'b0, w_eff});
        last0 = (r_out_row >= h21)
                || ((r_out_row == (h21 - 21'd1)) && (r_out_col == (w_eff - 11'd1)));
    end

    // Advance the position counters for an accepted request
    always_comb begin
        col_inc   = r_in_col + 11'd1;
        n_in_col  = col_inc;
        n_in_row  = r_in_row;
        if (col_inc >= w_eff) begin
            n_in_col = '0;
            if (r_in_row < ROW_SAT) begin
                n_in_row = r_in_row + 11'd1;
            end
        end

        n_out_pos = r_out_pos;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        if (emit0) begin
            if (last0) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_pos = '0;
                n_out_row = '0;
                n_out_col = '0;
            end else if (r_out_pos == COUNT_MAX) begin
                n_out_pos = '0;
                n_out_row = '0;
                n_out_col = '0;
            end else begin
                n_out_pos = r_out_pos + 21'd1;
                if ((r_out_col + 11'd1) == w_eff) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + 21'd1;
                end else begin
                    n_out_col = r_out_col + 11'd1;
                end
            end
        end
    end

    // One restoring step of position / width
    always_comb begin
        div_trial = {r_div_rem, r_div_q[COUNT_W-1]};
        if (div_trial >= {1'b0, w_eff}) begin
            n_div_rem = CFG_W'(div_trial - {1'b0, w_eff});
            n_div_q   = {r_div_q[COUNT_W-2:0], 1'b1};
        end else begin
            n_div_rem = div_trial[CFG_W-1:0];
            n_div_q   = {r_div_q[COUNT_W-2:0], 1'b0};
        end
    end

    // Configuration, counters and divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= SIZE_RESET;
            r_height  <= SIZE_RESET;
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_pos <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_div_cnt <= '0;
            r_div_q   <= '0;
            r_div_rem <= '0;
        end else begin
            if (cfg_we) begin
                unique case (i_cfg_index)
                    CFG_IMAGE_WIDTH: begin
                        r_width   <= i_cfg_data;
                        r_div_cnt <= DIV_STEPS;
                        r_div_q   <= r_out_pos;
                        r_div_rem <= '0;
                    end
                    CFG_IMAGE_HEIGHT: begin
                        r_height <= i_cfg_data;
                    end
                endcase
            end else if (div_busy) begin
                r_div_cnt <= r_div_cnt - 5'd1;
                r_div_q   <= n_div_q;
                r_div_rem <= n_div_rem;
                if (r_div_cnt == 5'd1) begin
                    r_out_row <= n_div_q;
                    r_out_col <= n_div_rem;
                end
            end
            if (in_accept) begin
                r_in_row  <= n_in_row;
                r_in_col  <= n_in_col;
                r_out_pos <= n_out_pos;
                r_out_row <= n_out_row;
                r_out_col <= n_out_col;
            end
        end
    end

    // Line store: bit 1 upper line, bit 0 middle line
    hbd_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (a_go),
        .i_waddr (r_a_addr),
        .i_wdata (wr_data),
        .i_re    (in_accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // Forward the write that lands in the same cycle as the read
    assign line_rd = r_byp ? r_byp_data : ram_rdata;
    assign wr_data = {line_rd[0], r_a_hole};

    // Shift the window and test the center pixel
    always_comb begin
        logic nbr_ok;
        nw[2:0] = {line_rd[1], r_window[2:1]};
        nw[5:3] = {line_rd[0], r_window[5:4]};
        nw[8:6] = {r_a_hole, r_window[8:7]};
        border  = 1'b0;
        for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
                nbr_ok = r_a_rowok[dr];
                if (dc == 0) nbr_ok = nbr_ok && r_a_colok[0];
                if (dc == 2) nbr_ok = nbr_ok && r_a_colok[1];
                if (!(dr == 1 && dc == 1) && nbr_ok && !nw[dr * 3 + dc]) begin
                    border = 1'b1;
                end
            end
        end
        border  = border && nw[4];
        n_total = (border && (r_total != COUNT_MAX)) ? r_total + 21'd1 : r_total;
    end

    // Window stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_byp     <= 1'b0;
            r_window  <= '0;
            r_total   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_a_valid <= 1'b1;
                r_byp     <= a_go && (r_a_addr == rd_addr);
            end else if (a_go) begin
                r_a_valid <= 1'b0;
            end
            if (a_go) begin
                r_window <= (r_a_emit && r_a_last) ? '0 : nw;
                if (r_a_emit) begin
                    r_total <= r_a_last ? '0 : n_total;
                end
            end
            if (a_go && r_a_emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Window stage and output payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_emit   <= emit0;
            r_a_hole   <= hole0;
            r_a_last   <= last0;
            r_a_rowok  <= rowok0;
            r_a_colok  <= colok0;
            r_a_addr   <= rd_addr;
            r_byp_data <= wr_data;
        end
        if (a_go && r_a_emit) begin
            r_o_data.is_border    <= border;
            r_o_data.frame_last   <= r_a_last;
            r_o_data.border_count <= n_total;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    // No request enters while the divider runs
    a_div_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> !o_in_ready)
        else $error("request accepted during position divide");

    // Output column stays inside the row once the divider is done
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !div_busy |-> (r_out_col < w_eff))
        else $error("output column beyond image width");

    // A border result always carries a nonzero count
    a_border_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.is_border) |-> (o_out_data.border_count != '0))
        else $error("border result with zero count");

endmodule

// ===== sv/hbd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is enabled.
// No dependencies.
module hbd_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
